// File: design/escape_sequence_decoder_macros.svh
// Assertion macros for the escape sequence decoder.
// Define NO_ASSERTIONS to compile them out.
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape_sequence_decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ESD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape_sequence_decoder: next-cycle check failed");

`else

`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ESD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

    // Decoder mode
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX1  = 2'd2,
        MODE_HEX2  = 2'd3
    } mode_t;

    // Per-string decoder state
    typedef struct packed {
        mode_t      mode;
        logic [3:0] nibble;
        logic       err;
    } state_t;

    // One result item
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       string_error;
        logic       string_end;
    } result_t;

    localparam state_t STATE_RESET = '{mode: MODE_PLAIN, nibble: 4'h0, err: 1'b0};

    // Character codes
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;

    // Strict hex digit: {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h00;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Simple escape letter to byte; zero means unknown
    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h61:       r = 8'h07; // a
            8'h62:       r = 8'h08; // b
            8'h66:       r = 8'h0C; // f
            8'h6E:       r = 8'h0A; // n
            8'h72:       r = 8'h0D; // r
            8'h74:       r = 8'h09; // t
            8'h76:       r = 8'h0B; // v
            CHAR_BSLASH: r = CHAR_BSLASH;
            CHAR_QUOTE:  r = CHAR_QUOTE;
            CHAR_DQUOTE: r = CHAR_DQUOTE;
            default:     r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: design/esd_step.sv
`timescale 1ns / 1ps

// Decode one character against the current state.
module esd_step (
    input  esd_pkg::state_t  st,
    input  logic [7:0]       ch,
    input  logic             last,
    output esd_pkg::result_t res,
    output esd_pkg::state_t  st_next
);
    import esd_pkg::*;

    logic [4:0] hd;
    logic [7:0] esc;
    logic [7:0] hex_byte;
    logic       err;
    logic       valid;
    logic [7:0] dec_byte;

    assign hd       = hex_digit(ch);
    assign esc      = simple_escape(ch);
    assign hex_byte = {st.nibble, hd[3:0]};

    // Mode update and error detection
    always_comb
    begin
        st_next  = st;
        valid    = 1'b0;
        dec_byte = 8'h00;
        err      = 1'b0;
        if (!st.err)
        begin
            if (ch < CHAR_SPACE || ch > CHAR_TILDE)
            begin
                err = 1'b1;
            end
            else
            begin
                case (st.mode)
                    MODE_PLAIN:
                    begin
                        if (ch == CHAR_BSLASH)
                        begin
                            st_next.mode = MODE_ESC;
                        end
                        else
                        begin
                            valid    = 1'b1;
                            dec_byte = ch;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (ch == CHAR_X)
                        begin
                            st_next.mode = MODE_HEX1;
                        end
                        else if (esc == 8'h00)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            valid        = 1'b1;
                            dec_byte     = esc;
                            st_next.mode = MODE_PLAIN;
                        end
                    end
                    MODE_HEX1:
                    begin
                        if (!hd[4])
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            st_next.nibble = hd[3:0];
                            st_next.mode   = MODE_HEX2;
                        end
                    end
                    MODE_HEX2:
                    begin
                        if (!hd[4] || hex_byte == 8'h00)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            valid        = 1'b1;
                            dec_byte     = hex_byte;
                            st_next.mode = MODE_PLAIN;
                        end
                    end
                    default:
                    begin
                        st_next.mode = MODE_PLAIN;
                    end
                endcase
            end
            // string ends inside an escape
            if (!err && last && st_next.mode != MODE_PLAIN)
            begin
                err = 1'b1;
            end
            if (err)
            begin
                valid        = 1'b0;
                dec_byte     = 8'h00;
                st_next.err  = 1'b1;
                st_next.mode = MODE_PLAIN;
            end
        end
        res.byte_valid   = valid;
        res.out_byte     = dec_byte;
        res.string_error = st_next.err;
        res.string_end   = last;
        // state clears after the last character
        if (last)
        begin
            st_next = STATE_RESET;
        end
    end

endmodule

// File: design/escape_sequence_decoder.sv
`timescale 1ns / 1ps
// Pipeline: an accepted item is held in the stage-1 registers, then decoded into the result register,
// where its result waits until it is taken.
// Throughput: one item per cycle while the result is not stalled; the decode state is updated
// when an item is loaded into the result register. Both registers form a pipeline that only stalls
// when the result is not taken. Reset (rst_n low, asynchronous) empties the pipeline and returns
// the state to plain character mode with no error and a zero hex nibble.
module escape_sequence_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] out_byte,
    output logic       string_error,
    output logic       string_end
);
    import esd_pkg::*;

    `include "escape_sequence_decoder_macros.svh"

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    state_t     state_reg;
    state_t     state_next;
    logic       load_out;
    logic       take_in;

    // Pipeline flow
    assign load_out = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !load_out;
    assign take_in  = in_valid && !in_stall;

    esd_step u_step (
        .st      (state_reg),
        .ch      (s1_char_reg),
        .last    (s1_last_reg),
        .res     (res_next),
        .st_next (state_next)
    );

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (take_in)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_char_reg <= in_char;
            s1_last_reg <= is_last;
        end
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_valid   = res_reg.byte_valid;
    assign out_byte     = res_reg.out_byte;
    assign string_error = res_reg.string_error;
    assign string_end   = res_reg.string_end;

    // A decoded byte is never zero
    `ESD_ASSERT_IMP(a_nonzero_byte, clk, rst_n, out_valid_reg && res_reg.byte_valid, res_reg.out_byte != 8'h00)
    // After the last character the state is back at reset
    `ESD_ASSERT_NEXT(a_end_clears, clk, rst_n, load_out && s1_last_reg, state_reg == STATE_RESET)
    // An errored string stays in plain mode
    `ESD_ASSERT_IMP(a_err_plain, clk, rst_n, state_reg.err, state_reg.mode == MODE_PLAIN)
    // A byte is never given with the error flag set
    `ESD_ASSERT_IMP(a_err_no_byte, clk, rst_n, out_valid_reg && res_reg.string_error, !res_reg.byte_valid)

endmodule

// File: tb/escape_sequence_decoder_tb.sv
`timescale 1ns / 1ps

module escape_sequence_decoder_tb;

    import esd_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES  = 16;    // quiet time after the last result
    localparam int RANDOM_ITEMS  = 1550;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    // DUT interface
    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'h00;
    logic       is_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       string_error;
    logic       string_end;

    // Stimulus and scoreboard
    char_item_t pending_chars[$];
    result_t    expected_results[$];
    int         mismatch_count = 0;
    int         results_checked = 0;
    int         idle_cycles = 0;
    logic       in_taken = 1'b0;
    logic       out_taken = 1'b0;

    // Decoder state mirrored by the predictor
    mode_t      esc_mode = MODE_PLAIN;
    logic [3:0] hex_hi = 4'h0;
    logic       err_latched = 1'b0;

    // Handshake pacing
    int         send_gap = 0;
    int         stall_left = 0;
    bit         send_steady = 1'b0;
    bit         recv_steady = 1'b0;

    escape_sequence_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_char      (in_char),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .string_error (string_error),
        .string_end   (string_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Strict hex digit value, -1 for anything else (no space, no sign)
    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    // Byte produced by a one-letter escape, zero when the letter is not one
    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        case (c)
            "a":         return 8'd7;
            "b":         return 8'd8;
            "f":         return 8'd12;
            "n":         return 8'd10;
            "r":         return 8'd13;
            "t":         return 8'd9;
            "v":         return 8'd11;
            CHAR_BSLASH: return CHAR_BSLASH;
            CHAR_QUOTE:  return CHAR_QUOTE;
            CHAR_DQUOTE: return CHAR_DQUOTE;
            default:     return 8'd0;
        endcase
    endfunction

    // Predict the result of one accepted character and advance the mirror state
    task automatic decode_char(input logic [7:0] c, input logic last, output result_t res);
        logic bad;
        int   nib;
        logic [7:0] code;
        logic [7:0] hex_byte;
        bad = 1'b0;
        nib = hex_val(c);
        code = escape_byte(c);
        hex_byte = {hex_hi, nib[3:0]};
        res = '0;
        res.string_end = last;
        if (!err_latched)
        begin
            if (c < CHAR_SPACE || c > CHAR_TILDE)
            begin
                bad = 1'b1;
            end
            else
            begin
                case (esc_mode)
                    MODE_PLAIN:
                    begin
                        if (c == CHAR_BSLASH)
                        begin
                            esc_mode = MODE_ESC;
                        end
                        else
                        begin
                            res.byte_valid = 1'b1;
                            res.out_byte = c;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (c == CHAR_X)
                        begin
                            esc_mode = MODE_HEX1;
                        end
                        else if (code == 8'd0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            res.byte_valid = 1'b1;
                            res.out_byte = code;
                            esc_mode = MODE_PLAIN;
                        end
                    end
                    MODE_HEX1:
                    begin
                        if (nib < 0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            hex_hi = nib[3:0];
                            esc_mode = MODE_HEX2;
                        end
                    end
                    default:
                    begin
                        if (nib < 0 || hex_byte == 8'd0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            res.byte_valid = 1'b1;
                            res.out_byte = hex_byte;
                            esc_mode = MODE_PLAIN;
                        end
                    end
                endcase
            end
            // string closed in the middle of an escape
            if (!bad && last && esc_mode != MODE_PLAIN)
            begin
                bad = 1'b1;
            end
            if (bad)
            begin
                res.byte_valid = 1'b0;
                res.out_byte = 8'd0;
                err_latched = 1'b1;
                esc_mode = MODE_PLAIN;
            end
        end
        res.string_error = err_latched;
        if (last)
        begin
            esc_mode = MODE_PLAIN;
            hex_hi = 4'h0;
            err_latched = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic push_char(input logic [7:0] c, input logic last);
        char_item_t item;
        item.ch = c;
        item.last = last;
        pending_chars.push_back(item);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(32, 126));
        end
        while (c == CHAR_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] rand_hex_digit(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'("0" + v);
        end
        return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    // Space and plus are the usual strtol leftovers, so weight them up
    function automatic logic [7:0] rand_bad_digit();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = CHAR_SPACE;
            1:       c = "+";
            default:
            begin
                do
                begin
                    c = 8'($urandom_range(32, 126));
                end
                while (hex_val(c) >= 0);
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_nonprint();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
    endfunction

    // One string: mostly well formed, sometimes with a single fault and trailing noise
    task automatic push_random_string();
        logic [7:0] s[$];
        logic [7:0] c;
        logic [7:0] hv;
        int         n_tokens;
        int         fault_at;
        int         depth;
        bit         cut_short;
        n_tokens = $urandom_range(1, 10);
        fault_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_tokens - 1) : -1;
        cut_short = 1'b0;
        for (int t = 0; t < n_tokens && !cut_short; t++)
        begin
            if (t == fault_at)
            begin
                case ($urandom_range(0, 4))
                    0: s.push_back(rand_nonprint());
                    1:
                    begin
                        do
                        begin
                            c = 8'($urandom_range(32, 126));
                        end
                        while (escape_byte(c) != 8'd0 || c == CHAR_X);
                        s.push_back(CHAR_BSLASH);
                        s.push_back(c);
                    end
                    2:
                    begin
                        s.push_back(CHAR_BSLASH);
                        s.push_back(CHAR_X);
                        if ($urandom_range(0, 1))
                        begin
                            s.push_back(rand_hex_digit(4'($urandom_range(0, 15))));
                        end
                        s.push_back(rand_bad_digit());
                    end
                    3:
                    begin
                        s.push_back(CHAR_BSLASH);
                        s.push_back(CHAR_X);
                        s.push_back(CHAR_0);
                        s.push_back(CHAR_0);
                    end
                    default:
                    begin
                        // end the string inside an escape
                        depth = $urandom_range(0, 2);
                        s.push_back(CHAR_BSLASH);
                        if (depth > 0)
                        begin
                            s.push_back(CHAR_X);
                        end
                        if (depth > 1)
                        begin
                            s.push_back(rand_hex_digit(4'($urandom_range(0, 15))));
                        end
                        cut_short = 1'b1;
                    end
                endcase
                if (!cut_short)
                begin
                    repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    2:
                    begin
                        do
                        begin
                            c = 8'($urandom_range(32, 126));
                        end
                        while (escape_byte(c) == 8'd0);
                        s.push_back(CHAR_BSLASH);
                        s.push_back(c);
                    end
                    3:
                    begin
                        hv = 8'($urandom_range(1, 255));
                        s.push_back(CHAR_BSLASH);
                        s.push_back(CHAR_X);
                        s.push_back(rand_hex_digit(hv[7:4]));
                        s.push_back(rand_hex_digit(hv[3:0]));
                    end
                    default: s.push_back(rand_plain());
                endcase
            end
        end
        foreach (s[i])
        begin
            push_char(s[i], i == s.size() - 1);
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int base;
        // directed strings: printable limits, escapes, hex limits and each fault
        push_text(" ~\\t\\xFf");
        push_text("\\x01\\");
        push_text("\\x00");
        push_text("\\x+");
        push_text("\\x 7");
        push_text("\\qA");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        base = pending_chars.size();
        while (pending_chars.size() < base + RANDOM_ITEMS)
        begin
            push_random_string();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Driver: presents characters on the falling edge, holds them while stalled
    always @(negedge clk)
    begin
        char_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_taken)
        begin
            // stalled: keep the item as is
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap--;
        end
        else if (pending_chars.size() != 0)
        begin
            item = pending_chars.pop_front();
            in_char <= item.ch;
            is_last <= item.last;
            in_valid <= 1'b1;
            if ($urandom_range(0, 49) == 0)
            begin
                send_steady = !send_steady;
            end
            send_gap = send_steady ? 0 : $urandom_range(0, 4);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: after each taken result, stall for a random number of cycles
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                recv_steady = !recv_steady;
            end
            stall_left = recv_steady ? 0 : $urandom_range(0, 4);
        end
        if (rst_n && stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: checks results, predicts accepted characters, runs the watchdog
    always @(posedge clk)
    begin
        result_t want;
        result_t predicted;
        in_taken <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_checked));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (byte_valid !== want.byte_valid)
                    begin
                        report_mismatch($sformatf("result %0d byte_valid: want %b got %b",
                                                  results_checked, want.byte_valid, byte_valid));
                    end
                    if (out_byte !== want.out_byte)
                    begin
                        report_mismatch($sformatf("result %0d out_byte: want %h got %h",
                                                  results_checked, want.out_byte, out_byte));
                    end
                    if (string_error !== want.string_error)
                    begin
                        report_mismatch($sformatf("result %0d string_error: want %b got %b",
                                                  results_checked, want.string_error,
                                                  string_error));
                    end
                    if (string_end !== want.string_end)
                    begin
                        report_mismatch($sformatf("result %0d string_end: want %b got %b",
                                                  results_checked, want.string_end, string_end));
                    end
                end
                results_checked++;
            end

            if (in_valid && !in_stall)
            begin
                decode_char(in_char, is_last, predicted);
                expected_results.push_back(predicted);
            end

            // watchdog on handshake activity
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
